@@ design/icfg_pkg.sv @@
// Shared types and constants of the canvas fit geometry unit.
`default_nettype none
package icfg_pkg;

  localparam int DIM_BITS = 16;
  localparam int PROD_BITS = 2 * DIM_BITS;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = PROD_BITS / DIV_STEPS;
  localparam int DIV_LAT = DIV_STAGES + 1;

  localparam int IN_TDATA_BITS = 40;
  localparam int OUT_TDATA_BITS = 104;
  localparam int CFG_ADDR_BITS = 4;

  typedef logic [DIM_BITS-1:0] dim_t;
  typedef logic [PROD_BITS-1:0] prod_t;

  localparam logic [1:0] REG_CANVAS_WIDTH = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CANVAS_FORMAT = 2'd2;

  localparam logic [1:0] FMT_MONO = 2'd0;
  localparam logic [1:0] FMT_420 = 2'd1;
  localparam logic [1:0] FMT_422 = 2'd2;
  localparam logic [1:0] FMT_444 = 2'd3;

  localparam logic [2:0] SIT_LEFT = 3'd0;
  localparam logic [2:0] SIT_CENTER = 3'd1;
  localparam logic [2:0] SIT_TOPLEFT = 3'd2;
  localparam logic [2:0] SIT_TOP = 3'd3;
  localparam logic [2:0] SIT_BOTTOMLEFT = 3'd4;
  localparam logic [2:0] SIT_BOTTOM = 3'd5;
  localparam logic [2:0] SIT_RSVD_A = 3'd6;
  localparam logic [2:0] SIT_RSVD_B = 3'd7;

  typedef enum logic [1:0] {
    BR_FIT,
    BR_KEEP_W,
    BR_KEEP_H,
    BR_DIV
  } branch_t;

  // Sideband beside the aspect dividers
  typedef struct packed {
    logic    err;
    logic    trans;
    logic    hflip;
    logic [2:0] osit;
    dim_t    tw;
    dim_t    th;
    branch_t br;
    logic    ux2;
    logic    uy2;
  } aspect_sb_t;

  // Sideband beside the scaling dividers
  typedef struct packed {
    logic err;
    logic trans;
    logic hflip;
    logic [2:0] osit;
    dim_t cropx;
    dim_t cropy;
    dim_t cropw;
    dim_t croph;
    logic fits;
  } crop_sb_t;

endpackage
`default_nettype wire

@@ design/image_canvas_fit_geometry_unit.sv @@
// Canvas fit geometry unit: top level with APB registers and the full pipeline.
// Usage:
//  - Input stream in_*: one source description per transfer (width, height,
//    chroma format, chroma siting).
//  - Output stream out_*: one geometry result per input, in order; out_tuser
//    carries the error flag, and an error result has all of out_tdata zero.
//  - APB port cfg_*: canvas width (0x0), height (0x4), chroma format (0x8).
//    Write registers only while the pipeline is empty.
//  - Throughput: one item per cycle while out_* is not stalled. Each
//    result passes through two chained dividers (aspect crop, then scale
//    to canvas).
//  - Stall: the whole pipeline holds while the output register is full and
//    out_tready is low; in_tready drops in the same cycle.
//  - Reset clears all valid bits and loads the canvas 512x512, 4:2:0.
`default_nettype none
module image_canvas_fit_geometry_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // w[15:0], h[31:16], format[33:32], siting[36:34], zero pad
  input  wire logic [icfg_pkg::IN_TDATA_BITS-1:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // transpose[0], hflip[1], siting[4:2], crop_x[20:5], crop_y[36:21],
  // crop_w[52:37], crop_h[68:53], embed_w[84:69], embed_h[100:85],
  // need_resize[101], zero pad
  output logic [icfg_pkg::OUT_TDATA_BITS-1:0] out_tdata,
  // geom_error[0]
  output logic             out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [icfg_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import icfg_pkg::*;

  // ---------------- configuration ----------------
  dim_t cw_r, ch_r;
  logic [1:0] cfmt_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= dim_t'(512);
      ch_r <= dim_t'(512);
      cfmt_r <= FMT_420;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_CANVAS_WIDTH:  cw_r <= cfg_pwdata[DIM_BITS-1:0];
        REG_CANVAS_HEIGHT: ch_r <= cfg_pwdata[DIM_BITS-1:0];
        REG_CANVAS_FORMAT: cfmt_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_CANVAS_WIDTH:  cfg_prdata = {16'd0, cw_r};
      REG_CANVAS_HEIGHT: cfg_prdata = {16'd0, ch_r};
      REG_CANVAS_FORMAT: cfg_prdata = {30'd0, cfmt_r};
      default:           cfg_prdata = '0;
    endcase
  end

  logic cx2, cy2;
  assign cx2 = (cfmt_r == FMT_420) || (cfmt_r == FMT_422);
  assign cy2 = (cfmt_r == FMT_420);

  // ---------------- global advance ----------------
  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---------------- input register ----------------
  logic v0_r;
  dim_t w_r, h_r;
  logic [1:0] fmt_r;
  logic [2:0] sit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= in_tdata[15:0];
      h_r <= in_tdata[31:16];
      fmt_r <= in_tdata[33:32];
      sit_r <= in_tdata[36:34];
    end
  end

  // ---------------- stage A: checks, orientation, siting, branch, aspect products ----------------
  aspect_sb_t a_sb;
  prod_t a_num_w, a_num_h;
  logic sx2, sy2, fit_p, fit_t, land_s, land_c;

  always_comb begin
    sx2 = (fmt_r == FMT_420) || (fmt_r == FMT_422);
    sy2 = (fmt_r == FMT_420);
    fit_p = (w_r <= cw_r) && (h_r <= ch_r);
    fit_t = (w_r <= ch_r) && (h_r <= cw_r);
    land_s = w_r >= h_r;
    land_c = cw_r >= ch_r;
    a_sb = '0;
    a_sb.err = (w_r == '0) || (h_r == '0) || (sx2 && w_r[0]) || (sy2 && h_r[0]);
    if (fit_p) a_sb.trans = 1'b0;
    else if (fit_t) a_sb.trans = 1'b1;
    else a_sb.trans = land_s != land_c;
    a_sb.tw = a_sb.trans ? h_r : w_r;
    a_sb.th = a_sb.trans ? w_r : h_r;
    a_sb.osit = SIT_TOPLEFT;
    if (fmt_r == FMT_420) begin
      case (sit_r)
        SIT_LEFT:    a_sb.osit = a_sb.trans ? SIT_TOP : SIT_LEFT;
        SIT_CENTER:  a_sb.osit = SIT_CENTER;
        SIT_TOPLEFT: a_sb.osit = SIT_TOPLEFT;
        SIT_TOP:     a_sb.osit = a_sb.trans ? SIT_LEFT : SIT_TOP;
        SIT_BOTTOM: begin
          a_sb.osit = a_sb.trans ? SIT_LEFT : SIT_BOTTOM;
          a_sb.hflip = a_sb.trans;
        end
        SIT_BOTTOMLEFT: begin
          a_sb.osit = a_sb.trans ? SIT_TOPLEFT : SIT_BOTTOMLEFT;
          a_sb.hflip = a_sb.trans;
        end
        default: a_sb.err = 1'b1;
      endcase
    end
    if (fit_p || fit_t) a_sb.br = BR_FIT;
    else if ((a_sb.tw <= cw_r) && !land_c) a_sb.br = BR_KEEP_W;
    else if ((a_sb.th <= ch_r) && land_c) a_sb.br = BR_KEEP_H;
    else a_sb.br = BR_DIV;
    a_sb.ux2 = a_sb.trans ? sy2 : sx2;
    a_sb.uy2 = a_sb.trans ? sx2 : sy2;
    a_num_w = prod_t'(a_sb.th) * prod_t'(cw_r);
    a_num_h = prod_t'(a_sb.tw) * prod_t'(ch_r);
  end

  // aspect dividers and their sideband
  prod_t q_arw, q_arh;
  icfg_div u_div_arw (.clk, .en, .dividend(a_num_w), .divisor(ch_r), .quotient(q_arw));
  icfg_div u_div_arh (.clk, .en, .dividend(a_num_h), .divisor(cw_r), .quotient(q_arh));

  aspect_sb_t a_sb_r [DIV_LAT];
  logic       a_v_r  [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) a_v_r[i] <= 1'b0;
    end else if (en) begin
      a_v_r[0] <= v0_r;
      for (int i = 1; i < DIV_LAT; i++) a_v_r[i] <= a_v_r[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_sb_r[0] <= a_sb;
      for (int i = 1; i < DIV_LAT; i++) a_sb_r[i] <= a_sb_r[i-1];
    end
  end

  // ---------------- stage C: crop window ----------------
  aspect_sb_t ca;
  crop_sb_t c_sb;
  prod_t arw, arh;
  dim_t cw16, ch16, dx, dy;

  always_comb begin
    ca = a_sb_r[DIV_LAT-1];
    c_sb = '0;
    c_sb.err = ca.err;
    c_sb.trans = ca.trans;
    c_sb.hflip = ca.hflip;
    c_sb.osit = ca.osit;
    case (ca.br)
      BR_FIT: begin
        arw = prod_t'(ca.tw);
        arh = prod_t'(ca.th);
      end
      BR_KEEP_W: begin
        arw = prod_t'(ca.tw);
        arh = prod_t'(ch_r);
      end
      BR_KEEP_H: begin
        arw = prod_t'(cw_r);
        arh = prod_t'(ca.th);
      end
      default: begin
        arw = q_arw;
        arh = q_arh;
        if ((cw_r == '0) || (ch_r == '0)) c_sb.err = 1'b1;
      end
    endcase
    cw16 = (arw < prod_t'(ca.tw)) ? arw[DIM_BITS-1:0] : ca.tw;
    ch16 = (arh < prod_t'(ca.th)) ? arh[DIM_BITS-1:0] : ca.th;
    if (ca.ux2 || cx2) cw16[0] = 1'b0;
    if (ca.uy2 || cy2) ch16[0] = 1'b0;
    c_sb.cropw = cw16;
    c_sb.croph = ch16;
    dx = (ca.tw - cw16) >> 1;
    dy = (ca.th - ch16) >> 1;
    if (ca.ux2) dx[0] = 1'b0;
    if (ca.uy2) dy[0] = 1'b0;
    c_sb.cropx = dx;
    c_sb.cropy = dy;
    c_sb.fits = (cw16 <= cw_r) && (ch16 <= ch_r);
  end

  crop_sb_t c_sb_r;
  logic c_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (en) c_v_r <= a_v_r[DIV_LAT-1];
  end
  always_ff @(posedge clk) begin
    if (en) c_sb_r <= c_sb;
  end

  // ---------------- stage D: scaling products ----------------
  prod_t d_num_h_r, d_num_w_r;
  crop_sb_t d_sb_r;
  logic d_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (en) d_v_r <= c_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_num_h_r <= prod_t'(c_sb_r.croph) * prod_t'(cw_r);
      d_num_w_r <= prod_t'(c_sb_r.cropw) * prod_t'(ch_r);
      d_sb_r <= c_sb_r;
    end
  end

  prod_t q_eh, q_ew;
  icfg_div u_div_eh (.clk, .en, .dividend(d_num_h_r), .divisor(d_sb_r.cropw),
    .quotient(q_eh));
  icfg_div u_div_ew (.clk, .en, .dividend(d_num_w_r), .divisor(d_sb_r.croph),
    .quotient(q_ew));

  crop_sb_t e_sb_r [DIV_LAT];
  logic     e_v_r  [DIV_LAT];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) e_v_r[i] <= 1'b0;
    end else if (en) begin
      e_v_r[0] <= d_v_r;
      for (int i = 1; i < DIV_LAT; i++) e_v_r[i] <= e_v_r[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_sb_r[0] <= d_sb_r;
      for (int i = 1; i < DIV_LAT; i++) e_sb_r[i] <= e_sb_r[i-1];
    end
  end

  // ---------------- stage E: embed size and result ----------------
  crop_sb_t ee;
  prod_t ew, eh;
  logic e_err, e_resize;
  logic [OUT_TDATA_BITS-1:0] tdata_nxt;

  always_comb begin
    ee = e_sb_r[DIV_LAT-1];
    e_err = ee.err;
    ew = prod_t'(ee.cropw);
    eh = prod_t'(ee.croph);
    if (!ee.fits) begin
      if (ee.cropw == '0) begin
        e_err = 1'b1;
      end else if (q_eh > prod_t'(ch_r)) begin
        if (ee.croph == '0) e_err = 1'b1;
        ew = q_ew;
        eh = prod_t'(ch_r);
      end else begin
        ew = prod_t'(cw_r);
        eh = q_eh;
      end
    end
    if (cx2) ew[0] = 1'b0;
    if (cy2) eh[0] = 1'b0;
    e_resize = (ew != prod_t'(ee.cropw)) || (eh != prod_t'(ee.croph));
    tdata_nxt = '0;
    if (!e_err) begin
      tdata_nxt[0] = ee.trans;
      tdata_nxt[1] = ee.hflip;
      tdata_nxt[4:2] = ee.osit;
      tdata_nxt[20:5] = ee.cropx;
      tdata_nxt[36:21] = ee.cropy;
      tdata_nxt[52:37] = ee.cropw;
      tdata_nxt[68:53] = ee.croph;
      tdata_nxt[84:69] = ew[DIM_BITS-1:0];
      tdata_nxt[100:85] = eh[DIM_BITS-1:0];
      tdata_nxt[101] = e_resize;
    end
  end

  logic [OUT_TDATA_BITS-1:0] out_tdata_r;
  logic out_tuser_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= e_v_r[DIV_LAT-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= tdata_nxt;
      out_tuser_r <= e_err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

  // ---------------- assertions ----------------
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result carries nonzero geometry");

  a_hflip_trans: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0])
    else $error("hflip without transpose");

  a_resize: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && !out_tdata[101] |->
      out_tdata[84:69] == out_tdata[52:37] && out_tdata[100:85] == out_tdata[68:53])
    else $error("embed differs from crop without resize flag");

endmodule
`default_nettype wire

@@ design/icfg_div.sv @@
// Pipelined restoring divider, product width by dimension width.
`default_nettype none
module icfg_div (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire icfg_pkg::prod_t       dividend,
  input  wire icfg_pkg::dim_t        divisor,
  output logic [icfg_pkg::PROD_BITS-1:0] quotient
);
  import icfg_pkg::*;

  dim_t  rem_r [DIV_STAGES];
  prod_t num_r [DIV_STAGES+1];
  dim_t  den_r [DIV_STAGES];
  dim_t  rem_nxt [DIV_STAGES];
  prod_t num_nxt [DIV_STAGES];

  always_comb begin
    logic [DIM_BITS:0] part;
    dim_t  rem_v;
    prod_t num_v;
    part = '0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_v = rem_r[s];
      num_v = num_r[s];
      for (int j = 0; j < DIV_STEPS; j++) begin
        part = {rem_v, num_v[PROD_BITS-1]};
        num_v = {num_v[PROD_BITS-2:0], 1'b0};
        if (part >= {1'b0, den_r[s]}) begin
          part = part - {1'b0, den_r[s]};
          num_v[0] = 1'b1;
        end
        rem_v = part[DIM_BITS-1:0];
      end
      rem_nxt[s] = rem_v;
      num_nxt[s] = num_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      num_r[0] <= dividend;
      den_r[0] <= divisor;
      for (int s = 0; s < DIV_STAGES - 1; s++) begin
        rem_r[s+1] <= rem_nxt[s];
        den_r[s+1] <= den_r[s];
      end
      for (int s = 0; s < DIV_STAGES; s++) num_r[s+1] <= num_nxt[s];
    end
  end

  assign quotient = num_r[DIV_STAGES];

endmodule
`default_nettype wire
